// ===== hw/rtl/fzc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzc_pkg
// Shared types, constants and helpers for the fuzzy binary32 compare pipeline.
// ----------------------------------------------------------------------------
package fzc_pkg;

    // Stage advance strobes, shared by both adder pipelines.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } fzc_adv_t;

    localparam logic [7:0]  EXP_ALL_ONES = 8'hff;
    localparam logic [7:0]  TOL_EXP_DROP = 8'd19;
    localparam logic [31:0] ZERO_TOL     = 32'h367f_0381;  // 3.8e-6
    localparam logic [31:0] TINY_TOL     = 32'h0554_ad2e;  // 1e-35

    // IEEE x <= y for operands that are not NaN; +0 and -0 compare equal.
    function automatic logic f32_le(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] kx;
        logic [31:0] ky;
        kx = x[31] ? ~x : {1'b1, x[30:0]};
        ky = y[31] ? ~y : {1'b1, y[30:0]};
        if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0))
        begin
            return 1'b1;
        end
        return (kx <= ky);
    endfunction

endpackage

// ===== hw/rtl/fzc_fadd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzc_fadd
// Three-stage binary32 adder, round to nearest even: align, add and count
// leading zeros, then normalize, round and pack. The second operand is finite.
// ----------------------------------------------------------------------------
module fzc_fadd (
    input  logic             clk,
    input  fzc_pkg::fzc_adv_t adv,
    input  logic [31:0]      a,
    input  logic [31:0]      t,
    output logic [31:0]      sum
);
    import fzc_pkg::*;

    // Stage A: order by magnitude and align the smaller operand.
    logic        mag_ge;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  diff;
    logic [4:0]  dsat;
    logic [49:0] wide;

    logic [26:0] a_big_reg;
    logic [26:0] a_sml_reg;
    logic [7:0]  a_exp_reg;
    logic        a_sign_reg;
    logic        a_sub_reg;
    logic        a_inf_reg;
    logic [31:0] a_val_reg;

    always_comb
    begin
        mag_ge = (a[30:0] >= t[30:0]);
        big    = mag_ge ? a : t;
        sml    = mag_ge ? t : a;
        eb     = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es     = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff   = eb - es;
        dsat   = (diff > 8'd26) ? 5'd26 : diff[4:0];
        wide   = {(sml[30:23] != 8'd0), sml[22:0], 26'd0} >> dsat;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            a_big_reg  <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
            a_sml_reg  <= {wide[49:24], |wide[23:0]};
            a_exp_reg  <= eb;
            a_sign_reg <= big[31];
            a_sub_reg  <= a[31] ^ t[31];
            a_inf_reg  <= (a[30:23] == EXP_ALL_ONES);
            a_val_reg  <= a;
        end
    end

    // Stage B: add or subtract, then find the leading one.
    logic [27:0] r;
    logic [4:0]  lz;

    logic [27:0] b_r_reg;
    logic [4:0]  b_lz_reg;
    logic [7:0]  b_exp_reg;
    logic        b_sign_reg;
    logic        b_inf_reg;
    logic [31:0] b_val_reg;

    always_comb
    begin
        r = a_sub_reg ? ({1'b0, a_big_reg} - {1'b0, a_sml_reg})
                      : ({1'b0, a_big_reg} + {1'b0, a_sml_reg});
        lz = 5'd28;
        for (int i = 0; i < 28; i++)
        begin
            if (r[i])
            begin
                lz = 5'(27 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            b_r_reg    <= r;
            b_lz_reg   <= lz;
            b_exp_reg  <= a_exp_reg;
            b_sign_reg <= a_sign_reg;
            b_inf_reg  <= a_inf_reg;
            b_val_reg  <= a_val_reg;
        end
    end

    // Stage C: normalize, round and pack. The left shift stops at the
    // smallest normal exponent, which leaves a subnormal result.
    logic [4:0]  lz_m1;
    logic [7:0]  eb_m1;
    logic [4:0]  sh;
    logic [26:0] n;
    logic [23:0] m24;
    logic        g;
    logic        s;
    logic [8:0]  e9;
    logic        inc;
    logic [30:0] packed31;
    logic [31:0] res;
    logic [31:0] c_res_reg;

    always_comb
    begin
        lz_m1 = b_lz_reg - 5'd1;
        eb_m1 = b_exp_reg - 8'd1;
        sh    = ({3'd0, lz_m1} <= eb_m1) ? lz_m1 : eb_m1[4:0];
        n     = b_r_reg[26:0] << sh;
        if (b_r_reg[27])
        begin
            m24 = b_r_reg[27:4];
            g   = b_r_reg[3];
            s   = |b_r_reg[2:0];
            e9  = {1'b0, b_exp_reg} + 9'd1;
        end
        else
        begin
            m24 = n[26:3];
            g   = n[2];
            s   = |n[1:0];
            e9  = n[26] ? ({1'b0, b_exp_reg} - {4'd0, sh}) : 9'd0;
        end
        inc      = g & (s | m24[0]);
        packed31 = {e9[7:0], m24[22:0]} + {30'd0, inc};
        if (b_inf_reg)
        begin
            res = b_val_reg;
        end
        else if (e9 >= 9'd255)
        begin
            res = {b_sign_reg, EXP_ALL_ONES, 23'd0};
        end
        else
        begin
            res = {b_sign_reg, packed31};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            c_res_reg <= res;
        end
    end

    assign sum = c_res_reg;

endmodule

// ===== hw/rtl/fuzzy_float32_compare_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_float32_compare_core
// Relative-tolerance "nearly equal" test on two binary32 bit patterns.
// ----------------------------------------------------------------------------
// An input beat carries first_value and second_value; an output beat carries
// near_equal, set when the operands are exactly equal or lie within a
// tolerance scaled to the larger operand (a fixed one when either is zero or
// the larger has a biased exponent below 19). A NaN operand always gives 0.
// The datapath is five register stages: tolerance selection, then two
// three-stage binary32 adders working side by side (operand plus and minus
// tolerance), then the final compares into the output register.
// One beat enters every cycle while the receiver takes results.
// When out_ready is low the stages fill up one by one and in_ready falls
// only once every stage holds a beat; nothing is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module fuzzy_float32_compare_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        near_equal
);
    import fzc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    fzc_adv_t adv;

    assign rdy5 = !out_valid_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign adv  = '{s2: rdy2, s3: rdy3, s4: rdy4};

    // Stage 1: classify and pick the tolerance.
    logic        nan_in;
    logic        eq_in;
    logic [31:0] bigger;
    logic [31:0] tol;

    always_comb
    begin
        nan_in = ((first_value[30:23] == EXP_ALL_ONES) && (first_value[22:0] != 23'd0))
              || ((second_value[30:23] == EXP_ALL_ONES) && (second_value[22:0] != 23'd0));
        eq_in  = !nan_in && ((first_value == second_value)
              || ((first_value[30:0] == 31'd0) && (second_value[30:0] == 31'd0)));
        bigger = f32_le(first_value, second_value) ? second_value : first_value;
        if ((first_value[30:0] == 31'd0) || (second_value[30:0] == 31'd0))
        begin
            tol = ZERO_TOL;
        end
        else if (bigger[30:23] < TOL_EXP_DROP)
        begin
            tol = TINY_TOL;
        end
        else
        begin
            tol = {1'b0, bigger[30:23] - TOL_EXP_DROP, 23'd0};
        end
    end

    logic [31:0] a1_reg, b1_reg, tol1_reg;
    logic        eq1_reg, nan1_reg;
    logic [31:0] b2_reg, b3_reg, b4_reg;
    logic        eq2_reg, eq3_reg, eq4_reg;
    logic        nan2_reg, nan3_reg, nan4_reg;
    logic        near_reg;
    logic        near_next;
    logic [31:0] hi;
    logic [31:0] lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            a1_reg   <= first_value;
            b1_reg   <= second_value;
            tol1_reg <= tol;
            eq1_reg  <= eq_in;
            nan1_reg <= nan_in;
        end
        if (rdy2)
        begin
            b2_reg   <= b1_reg;
            eq2_reg  <= eq1_reg;
            nan2_reg <= nan1_reg;
        end
        if (rdy3)
        begin
            b3_reg   <= b2_reg;
            eq3_reg  <= eq2_reg;
            nan3_reg <= nan2_reg;
        end
        if (rdy4)
        begin
            b4_reg   <= b3_reg;
            eq4_reg  <= eq3_reg;
            nan4_reg <= nan3_reg;
        end
        if (rdy5)
        begin
            near_reg <= near_next;
        end
    end

    fzc_fadd u_hi_add (
        .clk (clk),
        .adv (adv),
        .a   (a1_reg),
        .t   (tol1_reg),
        .sum (hi)
    );

    fzc_fadd u_lo_add (
        .clk (clk),
        .adv (adv),
        .a   (a1_reg),
        .t   ({~tol1_reg[31], tol1_reg[30:0]}),
        .sum (lo)
    );

    // A sum is NaN only when an operand is NaN, so the NaN flag alone covers that case.
    assign near_next = !nan4_reg && (eq4_reg || (f32_le(b4_reg, hi) && f32_le(lo, b4_reg)));

    assign in_ready   = rdy1;
    assign out_valid  = out_valid_reg;
    assign near_equal = near_reg;

endmodule

// ===== hw/rtl/fzc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzc_checker
// Port-level checks for the fuzzy compare core, bound to the top level.
// ----------------------------------------------------------------------------
module fzc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] first_value,
    input logic [31:0] second_value,
    input logic        out_valid,
    input logic        out_ready,
    input logic        near_equal
);

    logic same_beat;

    assign same_beat = in_valid && in_ready && (first_value == second_value)
                    && (first_value[30:23] != 8'hff);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(near_equal))
        else $error("output beat changed while stalled");

    // A receiver that takes results never backs up the input.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // Identical finite operands come out as equal when the output does not stall in between.
    a_same_equal: assert property (@(posedge clk) disable iff (!rst_n)
        $past(same_beat, 4) && $past(out_ready, 3) && $past(out_ready, 2)
        && $past(out_ready, 1) && out_ready |=> out_valid && near_equal)
        else $error("identical operands not reported equal");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight after reset");

endmodule

bind fuzzy_float32_compare_core fzc_checker u_fzc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_value  (first_value),
    .second_value (second_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .near_equal   (near_equal)
);

// ===== verif/fzc_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fzc_scoreboard
// Watches both channels of the fuzzy binary32 compare core, predicts each
// near_equal result with a bit-exact binary32 adder model and compares.
// ----------------------------------------------------------------------------
module fzc_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        near_equal,
    output int          errors,
    output int          pending
);
    import fzc_pkg::*;

    logic expected_q[$];

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    endfunction

    // Ordered x <= y for operands that are not NaN.
    function automatic logic ordered_le(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] kx;
        logic [31:0] ky;
        if (is_nan(x) || is_nan(y))
        begin
            return 1'b0;
        end
        if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0))
        begin
            return 1'b1;
        end
        kx = x[31] ? ~x : {1'b1, x[30:0]};
        ky = y[31] ? ~y : {1'b1, y[30:0]};
        return kx <= ky;
    endfunction

    // binary32 addition, round to nearest even, subnormals kept.
    function automatic logic [31:0] add_rne(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic [27:0] mb;
        logic [27:0] ml;
        logic [27:0] r;
        int          eb;
        int          el;
        int          d;
        logic        sticky;
        if (is_nan(a) || is_nan(b))
        begin
            return 32'h7fc0_0000;
        end
        if (a[30:23] == 8'hff)
        begin
            if ((b[30:23] == 8'hff) && (a[31] != b[31]))
            begin
                return 32'h7fc0_0000;
            end
            return a;
        end
        if (b[30:23] == 8'hff)
        begin
            return b;
        end
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            lit = b;
        end
        else
        begin
            big = b;
            lit = a;
        end
        if ((big[30:0] == 31'd0) && (lit[30:0] == 31'd0))
        begin
            return {big[31] & lit[31], 31'd0};
        end
        eb = (big[30:23] == 0) ? 1 : big[30:23];
        el = (lit[30:23] == 0) ? 1 : lit[30:23];
        mb = {1'b0, (big[30:23] != 0), big[22:0], 3'b000};
        ml = {1'b0, (lit[30:23] != 0), lit[22:0], 3'b000};
        d  = eb - el;
        if (d >= 28)
        begin
            sticky = (ml != 0);
            ml = 28'd0;
        end
        else
        begin
            sticky = ((ml & ((28'd1 << d) - 28'd1)) != 0);
            ml = ml >> d;
        end
        ml[0] = ml[0] | sticky;
        if (big[31] == lit[31])
        begin
            r = mb + ml;
        end
        else
        begin
            r = mb - ml;
        end
        if (r == 28'd0)
        begin
            return 32'd0;
        end
        if (r[27])
        begin
            r = {1'b0, r[27:2], r[1] | r[0]};
            eb = eb + 1;
        end
        while (!r[26] && (eb > 1))
        begin
            r = r << 1;
            eb = eb - 1;
        end
        if (r[2] && ((r[1:0] != 2'b00) || r[3]))
        begin
            r = r + 28'd8;
        end
        if (r[27])
        begin
            r = r >> 1;
            eb = eb + 1;
        end
        if (eb >= 255)
        begin
            return {big[31], 8'hff, 23'd0};
        end
        return {big[31], (r[26] ? eb[7:0] : 8'd0), r[25:3]};
    endfunction

    function automatic logic predict_near_equal(input logic [31:0] x1, input logic [31:0] x2);
        logic [31:0] tol;
        logic [31:0] bigger;
        logic [31:0] e;
        logic [31:0] hi;
        logic [31:0] lo;
        if (ordered_le(x1, x2) && ordered_le(x2, x1))
        begin
            return 1'b1;
        end
        if ((x1[30:0] == 31'd0) || (x2[30:0] == 31'd0))
        begin
            tol = ZERO_TOL;
        end
        else
        begin
            // A NaN makes the compare false, so the explicit NaN test takes x2 then.
            bigger = (ordered_le(x1, x2) || is_nan(x1) || is_nan(x2)) ? x2 : x1;
            e = bigger & 32'h7f80_0000;
            if (e < (32'(TOL_EXP_DROP) << 23))
            begin
                tol = TINY_TOL;
            end
            else
            begin
                tol = e - (32'(TOL_EXP_DROP) << 23);
            end
        end
        hi = add_rne(x1, tol);
        lo = add_rne(x1, {~tol[31], tol[30:0]});
        return ordered_le(x2, hi) && ordered_le(lo, x2);
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(predict_near_equal(first_value, second_value));
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("Unexpected result beat: near_equal=%0b", near_equal);
                    end
                    errors <= errors + 1;
                end
                else
                begin
                    if (near_equal !== expected_q[0])
                    begin
                        if (errors < 10)
                        begin
                            $display("Mismatch: near_equal expected %0b actual %0b",
                                     expected_q[0], near_equal);
                        end
                        errors <= errors + 1;
                    end
                    void'(expected_q.pop_front());
                end
            end
        end
    end

endmodule

// ===== verif/tb_fuzzy_float32_compare_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_float32_compare_core
// Drives operand pairs with bursty traffic and a stalling receiver; the
// scoreboard predicts and checks every near_equal result.
// ----------------------------------------------------------------------------
module tb_fuzzy_float32_compare_core;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic        near_equal;
    int          errors;
    int          pending;
    int          cycle_count = 0;

    localparam int CYCLE_LIMIT = 300000;

    fuzzy_float32_compare_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .near_equal   (near_equal)
    );

    fzc_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .near_equal   (near_equal),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: ready and stall runs of random length, stalled more often than not.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= ($urandom_range(0, 9) < 4);
        end
    end

    // Operand generator with a bias toward special encodings.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return {1'($urandom), 31'd0};
            1: return {1'($urandom), 8'hff, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
            2: return {1'($urandom), 8'h00, 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(15, 23)), 23'($urandom)};
            4: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        in_valid     <= 1'b1;
        first_value  <= a;
        second_value <= b;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        int          burst;
        int          sent;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        first_value  = 32'd0;
        second_value = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, infinities, NaN, the boundary at exponent 19, subnormals, negatives.
        send_pair(32'h0000_0000, 32'h8000_0000);
        send_pair(32'h0000_0000, 32'h3680_0000);
        send_pair(32'h0000_0000, 32'h3690_0000);
        send_pair(32'h8000_0000, 32'hb67f_0381);
        send_pair(32'h7f80_0000, 32'h7f80_0000);
        send_pair(32'hff80_0000, 32'hff80_0000);
        send_pair(32'h7f80_0000, 32'hff80_0000);
        send_pair(32'h7f80_0000, 32'h7f7f_ffff);
        send_pair(32'h7fc0_0000, 32'h7fc0_0000);
        send_pair(32'h3f80_0000, 32'hffff_ffff);
        send_pair(32'h0980_0000, 32'h0980_0001);
        send_pair(32'h0980_0000, 32'h0980_0000);
        send_pair(32'h0a00_0000, 32'h0a00_0001);
        send_pair(32'h0000_0001, 32'h0000_0002);
        send_pair(32'h807f_ffff, 32'h8000_0001);
        send_pair(32'h3f80_0000, 32'h3f80_0001);
        send_pair(32'h3f80_0000, 32'h3f80_0010);
        send_pair(32'h3f80_0000, 32'h3f80_0011);
        send_pair(32'hbf80_0000, 32'hbf80_0008);
        send_pair(32'hc000_0000, 32'hbf80_0000);
        send_pair(32'h7f7f_ffff, 32'h7f7f_fff0);
        send_pair(32'hffff_ffff, 32'h0000_0000);
        send_pair(32'h0400_0000, 32'h8400_0000);

        // Let the pipe drain once before the random part. The scoreboard has
        // recorded the last beat by the falling edge.
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(posedge clk);

        sent = 0;
        while (sent < 1700)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                a = pick_operand();
                case ($urandom_range(0, 3))
                    // Neighbors in bit order probe the tolerance boundary.
                    0: b = a + 32'($signed($urandom_range(0, 64)) - 32);
                    1: b = a ^ (32'd1 << $urandom_range(0, 31));
                    2: b = a;
                    default: b = pick_operand();
                endcase
                if ($urandom_range(0, 1))
                begin
                    send_pair(a, b);
                end
                else
                begin
                    send_pair(b, a);
                end
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                idle_cycles($urandom_range(1, 12));
            end
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== fuzzy_float32_compare_core.f =====
hw/rtl/fzc_pkg.sv
hw/rtl/fzc_fadd.sv
hw/rtl/fuzzy_float32_compare_core.sv
hw/rtl/fzc_checker.sv
verif/fzc_scoreboard.sv
verif/tb_fuzzy_float32_compare_core.sv
